// ----- rtl/core/online_kmeans_assigner_top_defines.svh -----
// Assertion macros for the online k-means assigner.
`ifndef ONLINE_KMEANS_ASSIGNER_TOP_DEFINES_SVH
`define ONLINE_KMEANS_ASSIGNER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define OKM_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define OKM_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ----- rtl/core/okm_pkg.sv -----
// Shared constants and types of the online k-means assigner.
`default_nettype none
package okm_pkg;
	localparam int MAX_DIMS = 8;
	localparam int MAX_CENTERS = 8;
	localparam int COORD_W = 16;
	localparam int SUM_W = 48;
	localparam int COUNT_W = 32;
	localparam int REG_W = 4;
	localparam int REG_DIMS = 0;
	localparam int REG_CENTERS = 1;
	localparam logic [COUNT_W-1:0] FULL_COUNT = '1;
endpackage
`default_nettype wire

// ----- rtl/core/online_kmeans_assigner_top.sv -----
// Top level of the online k-means assigner: sequencer, memories and result register.
//
//  channel  | signals                                   | dir
//  input    | valid, ready, coord_value                 | in
//  result   | out_valid, out_ready, center_index, ...   | out
//  config   | cfg_we, cfg_index, cfg_data               | in
//
// A coordinate that does not complete a point is stored in the point buffer.
// A seed point then writes its center over all MAX_DIMS dims, zero beyond the set ones.
// Any other point runs distances and the 20-step square root over C seeded centers and
// D dims, then the serial mean division per dim unless the winner's count is full.
// Reset clears the control state only; memories start undefined.
// A waiting result holds the sequencer at its last step; input is taken until then.
`default_nettype none
`include "online_kmeans_assigner_top_defines.svh"
module online_kmeans_assigner_top #(
	parameter int MAX_DIMS = okm_pkg::MAX_DIMS,
	parameter int MAX_CENTERS = okm_pkg::MAX_CENTERS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid,
	output logic                             ready,
	input  wire logic signed [15:0]          coord_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic             [2:0]           center_index,
	output logic                             became_seed,
	output logic             [31:0]          member_count,
	input  wire logic                        cfg_we,
	input  wire logic        [0:0]           cfg_index,
	input  wire logic        [3:0]           cfg_data
);
	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CW = $clog2(MAX_CENTERS);
	localparam int AW = DW + CW;
	localparam int DCW = $clog2(MAX_DIMS + 1);
	localparam int CCW = $clog2(MAX_CENTERS + 1);
	localparam int SW = okm_pkg::SUM_W;
	localparam int NW = okm_pkg::COUNT_W;
	localparam int ACCW = 40;

	typedef enum logic [3:0] {
		S_IDLE, S_SEED, S_DRD, S_DACC, S_SQRT, S_CMP,
		S_URD, S_UDIV, S_UWR, S_DONE
	} state_t;

	state_t state_q;
	logic [3:0] dims_q, cent_q;
	logic [DCW-1:0] pos_q;
	logic [CCW-1:0] seeded_q;
	logic [CW-1:0] prev_q, win_q, c_q;
	logic [DW-1:0] d_q;
	logic first_q;
	logic signed [15:0] pbuf_q [MAX_DIMS];
	logic [ACCW-1:0] acc_q, best_q, rem_q, root_q;
	logic [5:0] it_q;
	logic [NW-1:0] cnt_q;
	logic signed [SW-1:0] sum_q;
	logic [SW-1:0] num_q, quo_q;
	logic [SW:0] drem_q;
	logic neg_q;
	logic ovalid_q;
	logic [2:0] oidx_q;
	logic oseed_q;
	logic [NW-1:0] ocnt_q;

	logic [DCW-1:0] dims_eff;
	logic [CCW-1:0] cent_eff;
	always_comb begin
		dims_eff = (dims_q == 4'd0) ? DCW'(1) :
			((32'(dims_q) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_q));
		cent_eff = (cent_q == 4'd0) ? CCW'(1) :
			((32'(cent_q) > MAX_CENTERS) ? CCW'(MAX_CENTERS) : CCW'(cent_q));
	end

	// Memories: means, sums, counts.
	logic m_we, s_we, n_we;
	logic [AW-1:0] m_waddr, raddr;
	logic signed [15:0] m_wdata, m_rdata;
	logic [SW-1:0] s_wdata, s_rdata;
	logic [NW-1:0] n_wdata, n_rdata;
	logic [CW-1:0] n_addr;
	okm_ram #(.WIDTH(16), .DEPTH(MAX_CENTERS*MAX_DIMS)) u_means (
		.clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(raddr), .rdata(m_rdata));
	okm_ram #(.WIDTH(SW), .DEPTH(MAX_CENTERS*MAX_DIMS)) u_sums (
		.clk, .we(s_we), .waddr(m_waddr), .wdata(s_wdata), .raddr(raddr), .rdata(s_rdata));
	okm_ram #(.WIDTH(NW), .DEPTH(MAX_CENTERS)) u_counts (
		.clk, .we(n_we), .waddr(n_addr), .wdata(n_wdata), .raddr(n_addr), .rdata(n_rdata));

	logic [CW-1:0] cur_c;
	always_comb begin
		cur_c = (state_q == S_SEED) ? CW'(seeded_q) : ((state_q == S_DRD ||
			state_q == S_DACC) ? c_q : win_q);
		raddr = {cur_c, d_q};
		m_waddr = {cur_c, d_q};
		n_addr = cur_c;
		m_we = 1'b0;
		s_we = 1'b0;
		n_we = 1'b0;
		m_wdata = pbuf_q[d_q];
		s_wdata = SW'(pbuf_q[d_q]);
		n_wdata = NW'(1);
		if (state_q == S_SEED) begin
			m_we = 1'b1;
			s_we = 1'b1;
			n_we = (d_q == '0);
			if (32'(d_q) >= 32'(dims_eff)) begin
				m_wdata = '0;
				s_wdata = '0;
			end
		end else if (state_q == S_UWR) begin
			m_we = 1'b1;
			s_we = 1'b1;
			n_we = (d_q == '0);
			m_wdata = 16'(neg_q ? (~quo_q + 1'b1) : quo_q);
			s_wdata = sum_q;
			n_wdata = cnt_q;
		end
	end

	logic signed [16:0] diff;
	logic [16:0] mag;
	logic [ACCW-1:0] trial;
	logic [ACCW-1:0] sq_part;
	always_comb begin
		diff = 17'(pbuf_q[d_q]) - 17'(m_rdata);
		mag = diff[16] ? 17'(-diff) : 17'(diff);
		trial = {root_q[ACCW-3:0], 2'b01};
		sq_part = {rem_q[ACCW-3:0], acc_q[ACCW-1:ACCW-2]};
	end

	// A result is loaded only once the result register is free or being emptied.
	logic out_free, res_load;
	always_comb begin
		out_free = !ovalid_q || out_ready;
		res_load = 1'b0;
		case (state_q)
			S_SEED: res_load = out_free && (32'(d_q) == MAX_DIMS - 1);
			S_UDIV: res_load = out_free && (it_q == '0) && (d_q == '0) &&
				(n_rdata == okm_pkg::FULL_COUNT);
			S_UWR: res_load = out_free && (32'(d_q) + 1 >= 32'(dims_eff));
			default: res_load = 1'b0;
		endcase
	end

	assign ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dims_q <= 4'd1;
			cent_q <= 4'd2;
			pos_q <= '0;
			seeded_q <= '0;
			prev_q <= '0;
			ovalid_q <= 1'b0;
			win_q <= '0;
			c_q <= '0;
			d_q <= '0;
			first_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					1'(okm_pkg::REG_DIMS): dims_q <= cfg_data;
					1'(okm_pkg::REG_CENTERS): cent_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) begin
				ovalid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (valid && ready) begin
						if (32'(pos_q) < MAX_DIMS) pbuf_q[DW'(pos_q)] <= coord_value;
						if (pos_q + 1'b1 >= dims_eff) begin
							pos_q <= '0;
							d_q <= '0;
							if (seeded_q < cent_eff) begin
								state_q <= S_SEED;
							end else begin
								win_q <= (prev_q < CW'(seeded_q) || 32'(seeded_q) >
									32'(prev_q)) ? prev_q : '0;
								c_q <= (32'(prev_q) < 32'(seeded_q)) ? prev_q : '0;
								first_q <= 1'b1;
								acc_q <= '0;
								state_q <= S_DRD;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				S_SEED: begin
					if (32'(d_q) == MAX_DIMS - 1) begin
						if (res_load) begin
							oidx_q <= 3'(seeded_q);
							oseed_q <= 1'b1;
							ocnt_q <= NW'(1);
							seeded_q <= seeded_q + 1'b1;
							d_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_DRD: state_q <= S_DACC;
				S_DACC: begin
					acc_q <= acc_q + ACCW'(mag * mag);
					if (32'(d_q) + 1 >= 32'(dims_eff)) begin
						d_q <= '0;
						rem_q <= '0;
						root_q <= '0;
						it_q <= '0;
						state_q <= S_SQRT;
					end else begin
						d_q <= d_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_SQRT: begin
					// Restoring square root, one result bit per cycle from the top bit pair.
					if (sq_part >= trial) begin
						rem_q <= sq_part - trial;
						root_q <= {root_q[ACCW-2:0], 1'b1};
					end else begin
						rem_q <= sq_part;
						root_q <= {root_q[ACCW-2:0], 1'b0};
					end
					acc_q <= {acc_q[ACCW-3:0], 2'b00};
					if (it_q == 6'(ACCW/2 - 1)) state_q <= S_CMP;
					it_q <= it_q + 1'b1;
				end
				S_CMP: begin
					if (first_q || root_q < best_q) begin
						best_q <= root_q;
						if (!first_q) win_q <= c_q;
					end
					first_q <= 1'b0;
					acc_q <= '0;
					if (32'(c_q) + 1 >= 32'(seeded_q) && !first_q) begin
						state_q <= S_URD;
					end else begin
						c_q <= first_q ? ((win_q == '0) ? CW'(1) : '0) :
							((c_q + 1'b1 == win_q) ? c_q + 2'd2 : c_q + 1'b1);
						if ((first_q && (32'(seeded_q) == 1)) ||
							(!first_q && 32'(c_q) + ((c_q + 1'b1 == win_q) ? 2 : 1) >=
							32'(seeded_q))) begin
							state_q <= S_URD;
						end else begin
							state_q <= S_DRD;
						end
					end
					d_q <= '0;
				end
				S_URD: begin
					prev_q <= win_q;
					state_q <= S_UDIV;
					it_q <= '0;
				end
				S_UDIV: begin
					if (it_q == '0) begin
						if (d_q == '0) cnt_q <= n_rdata + 1'b1;
						sum_q <= s_rdata + SW'(pbuf_q[d_q]);
						// A full center is frozen: nothing is written back.
						if (d_q == '0 && n_rdata == okm_pkg::FULL_COUNT) begin
							if (res_load) begin
								ocnt_q <= n_rdata;
								oidx_q <= 3'(win_q);
								oseed_q <= 1'b0;
								state_q <= S_IDLE;
							end
						end else begin
							num_q <= '0;
							it_q <= 6'd1;
						end
					end else if (it_q == 6'd1) begin
						neg_q <= sum_q[SW-1];
						num_q <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
						drem_q <= '0;
						it_q <= 6'd2;
					end else begin
						// Restoring division, one quotient bit per cycle.
						if ({drem_q[SW-1:0], num_q[SW-1]} >= (SW+1)'(cnt_q)) begin
							drem_q <= {drem_q[SW-1:0], num_q[SW-1]} - (SW+1)'(cnt_q);
							quo_q <= {quo_q[SW-2:0], 1'b1};
						end else begin
							drem_q <= {drem_q[SW-1:0], num_q[SW-1]};
							quo_q <= {quo_q[SW-2:0], 1'b0};
						end
						num_q <= {num_q[SW-2:0], 1'b0};
						if (it_q == 6'(SW + 1)) state_q <= S_UWR;
						it_q <= it_q + 1'b1;
					end
				end
				S_UWR: begin
					if (32'(d_q) + 1 >= 32'(dims_eff)) begin
						if (res_load) begin
							oidx_q <= 3'(win_q);
							oseed_q <= 1'b0;
							ocnt_q <= cnt_q;
							d_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						d_q <= d_q + 1'b1;
						state_q <= S_URD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign center_index = oidx_q;
	assign became_seed = oseed_q;
	assign member_count = ocnt_q;

	`OKM_ASSERT_IMP(a_seed_count, clk, arst_n, out_valid && became_seed, member_count == 32'd1)
	`OKM_ASSERT_IMP(a_seed_bound, clk, arst_n, 1'b1, 32'(seeded_q) <= MAX_CENTERS)
	`OKM_ASSERT_IMP(a_busy, clk, arst_n, state_q != S_IDLE, !ready)
endmodule
`default_nettype wire

// ----- rtl/core/okm_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module okm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- tb/online_kmeans_assigner_top_tb.sv -----
// Self-checking testbench for the online k-means assigner: directed table, then random phases.
`default_nettype none
module online_kmeans_assigner_top_tb;
	typedef struct packed {
		logic [2:0]  center;
		logic        seed;
		logic [31:0] members;
	} assign_t;

	typedef struct {
		bit          is_cfg;
		bit [0:0]    reg_idx;
		bit [3:0]    reg_val;
		logic signed [15:0] coord;
		bit          typed;
		assign_t     want;
	} row_t;

	localparam assign_t NONE = '{3'd0, 1'b0, 32'd0};
	localparam int SETTLE_CYCLES = 1500;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_CYCLES = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic signed [15:0] coord_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] center_index;
	logic became_seed;
	logic [31:0] member_count;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	online_kmeans_assigner_top uut (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .ready(ready), .coord_value(coord_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.center_index(center_index), .became_seed(became_seed), .member_count(member_count),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the clustering state.
	bit [3:0] dims_reg = 4'd1;
	bit [3:0] centers_reg = 4'd2;
	int means [okm_pkg::MAX_CENTERS][okm_pkg::MAX_DIMS];
	longint sums [okm_pkg::MAX_CENTERS][okm_pkg::MAX_DIMS];
	int unsigned counts [okm_pkg::MAX_CENTERS];
	int point_coords [okm_pkg::MAX_DIMS];
	int seeded = 0;
	int last_winner = 0;
	int coord_pos = 0;

	assign_t pending_assignments [$];
	int fails = 0;
	int send_idle = 0;
	int recv_stall = 0;
	logic hold_req = 1'b0;
	bit hold_done = 0;
	int hold_left = 0;

	function automatic int clamp_setting(int v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned root, trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x) root = trial;
		end
		return root;
	endfunction

	function automatic longint unsigned center_dist(int c, int dims);
		longint unsigned acc, mag;
		longint diff;
		acc = 0;
		for (int d = 0; d < dims; d++) begin
			diff = longint'(point_coords[d]) - longint'(means[c][d]);
			mag = (diff < 0) ? longint'(-diff) : diff;
			acc += mag * mag;
		end
		return floor_sqrt(acc);
	endfunction

	// Consumes one coordinate; returns 1 when it completes a point.
	function automatic bit predict_assignment(input logic signed [15:0] v, output assign_t r);
		int dims, ncent, win;
		longint unsigned best, dd;
		dims = clamp_setting(dims_reg, okm_pkg::MAX_DIMS);
		ncent = clamp_setting(centers_reg, okm_pkg::MAX_CENTERS);
		r = NONE;
		if (coord_pos < okm_pkg::MAX_DIMS) point_coords[coord_pos] = v;
		coord_pos++;
		if (coord_pos < dims) return 0;
		coord_pos = 0;
		if (seeded < ncent) begin
			for (int d = 0; d < okm_pkg::MAX_DIMS; d++) begin
				means[seeded][d] = (d < dims) ? point_coords[d] : 0;
				sums[seeded][d] = means[seeded][d];
			end
			counts[seeded] = 1;
			r = '{seeded[2:0], 1'b1, 32'd1};
			seeded++;
			return 1;
		end
		win = (last_winner < seeded) ? last_winner : 0;
		best = center_dist(win, dims);
		for (int c = 0; c < seeded; c++) begin
			if (c != win) begin
				dd = center_dist(c, dims);
				if (dd < best) begin
					best = dd;
					win = c;
				end
			end
		end
		last_winner = win;
		if (counts[win] != okm_pkg::FULL_COUNT) begin
			counts[win]++;
			for (int d = 0; d < dims; d++) begin
				sums[win][d] += point_coords[d];
				means[win][d] = int'(sums[win][d] / longint'(counts[win]));
			end
		end
		r = '{win[2:0], 1'b0, counts[win]};
		return 1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fails++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_assignments.size() == 0) begin
				report("unexpected result, center_index", center_index, 0);
			end else begin
				assign_t e;
				e = pending_assignments.pop_front();
				if (center_index !== e.center) report("center_index", center_index, e.center);
				if (became_seed !== e.seed) report("became_seed", became_seed, e.seed);
				if (member_count !== e.members) report("member_count", member_count, e.members);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when asked.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_coord(input logic signed [15:0] v, input bit typed, input assign_t want);
		assign_t got;
		int gap;
		valid <= 1'b1;
		coord_value <= v;
		do @(posedge clk); while (!ready);
		if (predict_assignment(v, got)) pending_assignments.push_back(typed ? want : got);
		gap = 0;
		while ($urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drains all results, then lets a partial point's work run out.
	task automatic settle();
		valid <= 1'b0;
		while (pending_assignments.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input bit [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx[0:0];
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == okm_pkg::REG_DIMS) dims_reg = val;
		else centers_reg = val;
	endtask

	function automatic logic signed [15:0] pick_coord(int target);
		int x;
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			x = ((coord_pos < okm_pkg::MAX_DIMS) ? means[target][coord_pos] : 0) +
				$urandom_range(64) - 32;
			if (x > 32767) x = 32767;
			if (x < -32768) x = -32768;
		end else if (r < 75) begin
			x = $urandom_range(8) - 4;
		end else if (r < 90) begin
			x = $signed(16'($urandom));
		end else begin
			case ($urandom_range(3))
				0: x = 32767;
				1: x = -32768;
				2: x = 0;
				default: x = -1;
			endcase
		end
		return x[15:0];
	endfunction

	// Every center is seeded with all dimensions so that later dimension
	// settings never read an unwritten mean.
	row_t plan [33] = '{
		'{1, 1'(okm_pkg::REG_DIMS), 4'd15, 0, 0, NONE},
		'{1, 1'(okm_pkg::REG_CENTERS), 4'd0, 0, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 1, '{3'd0, 1'b1, 32'd1}},
		'{1, 1'(okm_pkg::REG_DIMS), 4'd1, 0, 0, NONE},
		'{0, 0, 0, -32768, 1, '{3'd0, 1'b0, 32'd2}},
		'{0, 0, 0, 32767, 1, '{3'd0, 1'b0, 32'd3}},
		'{0, 0, 0, 0, 1, '{3'd0, 1'b0, 32'd4}},
		'{1, 1'(okm_pkg::REG_DIMS), 4'd8, 0, 0, NONE},
		'{1, 1'(okm_pkg::REG_CENTERS), 4'd2, 0, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE}, '{0, 0, 0, -32768, 1, '{3'd1, 1'b1, 32'd1}},
		'{1, 1'(okm_pkg::REG_DIMS), 4'd1, 0, 0, NONE},
		// Equal distances to both centers; the previous winner keeps the item.
		'{0, 0, 0, 20479, 0, NONE},
		'{0, 0, 0, 32767, 0, NONE},
		'{0, 0, 0, 21708, 0, NONE},
		// Point cut short by lowering the dimension count mid-point.
		'{1, 1'(okm_pkg::REG_DIMS), 4'd3, 0, 0, NONE},
		'{0, 0, 0, -7, 0, NONE}, '{0, 0, 0, 7, 0, NONE},
		'{1, 1'(okm_pkg::REG_DIMS), 4'd2, 0, 0, NONE},
		'{0, 0, 0, 100, 0, NONE}
	};

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(plan); i++) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_coord(plan[i].coord, plan[i].typed, plan[i].want);
			end
		end

		target = 0;
		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: begin
					write_reg(okm_pkg::REG_DIMS, 4'd8);
					write_reg(okm_pkg::REG_CENTERS, 4'd8);
				end
				1: begin
					write_reg(okm_pkg::REG_DIMS, 4'd1);
					write_reg(okm_pkg::REG_CENTERS, 4'd8);
				end
				2: begin
					write_reg(okm_pkg::REG_DIMS, 4'd0);
					write_reg(okm_pkg::REG_CENTERS, 4'd15);
				end
				3: begin
					write_reg(okm_pkg::REG_DIMS, 4'd15);
					write_reg(okm_pkg::REG_CENTERS, 4'd1);
				end
				default: begin
					write_reg(okm_pkg::REG_DIMS, 4'($urandom_range(15)));
					write_reg(okm_pkg::REG_CENTERS, 4'($urandom_range(15)));
				end
			endcase
			case (p % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 75; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 75; end
				default: begin send_idle = 30; recv_stall = 30; end
			endcase
			// One-dimensional points each give a result, so the output backs up.
			if (p == 1) hold_req <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (coord_pos == 0) target = (seeded > 0) ? $urandom_range(seeded - 1) : 0;
				send_coord(pick_coord(target), 0, NONE);
			end
		end

		settle();
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/okm_pkg.sv
rtl/core/okm_ram.sv
rtl/core/online_kmeans_assigner_top.sv
tb/online_kmeans_assigner_top_tb.sv
